/* sv/sst_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the scoped symbol table
package sst_pkg;

   localparam int ACTION_W = 3;
   localparam int KEY_W    = 64;
   localparam int STATUS_W = 3;
   localparam int ADDR_W   = 10;
   localparam int DEPTH_W  = 8;
   localparam int COUNT_W  = 11;

   localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_MARK   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_ENTER  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_LEAVE  = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DUP     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_MISSING = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_AT_ZERO = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_LIMIT   = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the request word
      logic scan;     // walk the live entries
      logic commit;   // apply the action and drive the response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;  // request on the ports needs a table walk
      logic hit;        // entry under compare matches
      logic miss;       // walk ran off the live entries
   } stat_type;

endpackage

/* sv/sst_ctrl.sv */
`timescale 1ns / 1ps
// control state machine of the scoped symbol table
module sst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sst_pkg::stat_type stat,
   output sst_pkg::cmd_type cmd,
   output logic             busy
);
   import sst_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = stat.need_scan ? S_SCAN : S_DONE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit || stat.miss) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

/* sv/sst_dp.sv */
`timescale 1ns / 1ps
// table memories, scan pipeline and response registers of the scoped symbol table
module sst_dp #(
   parameter int ENTRIES   = 1024,
   parameter int MAX_DEPTH = 255
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sst_pkg::cmd_type              cmd,
   output sst_pkg::stat_type             stat,
   input  logic [sst_pkg::ACTION_W-1:0]  req_action,
   input  logic [sst_pkg::KEY_W-1:0]     req_name_key,
   input  logic                          req_init_flag,
   output logic                          rsp_strobe,
   output logic [sst_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sst_pkg::ADDR_W-1:0]    rsp_address,
   output logic [sst_pkg::DEPTH_W-1:0]   rsp_depth_now,
   output logic [sst_pkg::COUNT_W-1:0]   rsp_entry_count
);
   import sst_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0]   FULL_CNT  = CNT_W'(ENTRIES);
   localparam logic [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(MAX_DEPTH);

   logic [KEY_W-1:0]   key_mem   [ENTRIES];
   logic               init_mem  [ENTRIES];
   logic [DEPTH_W-1:0] scope_mem [ENTRIES];

   logic [ACTION_W-1:0] op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic                flag_ff;
   logic                zero_ff;
   logic [CNT_W-1:0]    scan_ff,  scan_in;
   logic                pend_ff,  pend_in;
   logic [IDX_W-1:0]    cidx_ff;
   logic [KEY_W-1:0]    rkey_ff;
   logic [DEPTH_W-1:0]  rscope_ff;
   logic                found_ff;
   logic [IDX_W-1:0]    fidx_ff;
   logic [CNT_W-1:0]    live_ff,  live_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic                strobe_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0]   addr_ff,   addr_in;

   logic               issue;
   logic               match;
   logic [IDX_W-1:0]   rd_idx;
   logic               add_wr;
   logic               init_wr;
   logic [IDX_W-1:0]   init_idx;
   logic [IDX_W-1:0]   live_idx;

   assign rd_idx   = scan_ff[IDX_W-1:0];
   assign live_idx = live_ff[IDX_W-1:0];
   assign issue    = cmd.scan && (scan_ff < live_ff);
   assign match    = (op_ff == ACT_LEAVE) ? (rscope_ff > depth_ff) : (rkey_ff == key_ff);

   assign stat.need_scan = (req_action == ACT_ADD) || (req_action == ACT_LOOKUP) ||
                           (req_action == ACT_MARK) ||
                           ((req_action == ACT_LEAVE) && (depth_ff != '0));
   assign stat.hit  = pend_ff && match;
   assign stat.miss = !pend_ff && !(scan_ff < live_ff);

   // scan pipeline: address issued one cycle, compared the next
   always_comb begin
      scan_in = scan_ff;
      pend_in = 1'b0;
      if (cmd.load) begin
         scan_in = '0;
      end else if (issue) begin
         scan_in = scan_ff + CNT_W'(1);
         pend_in = 1'b1;
      end
   end

   // action commit
   always_comb begin
      live_in   = live_ff;
      depth_in  = depth_ff;
      status_in = STAT_OK;
      addr_in   = '0;
      add_wr    = 1'b0;
      init_wr   = 1'b0;
      init_idx  = fidx_ff;
      if (cmd.load) begin
         if ((req_action == ACT_LEAVE) && (depth_ff != '0)) depth_in = depth_ff - DEPTH_W'(1);
      end else if (cmd.commit) begin
         unique case (op_ff)
            ACT_ADD: begin
               if (found_ff) begin
                  status_in = STAT_DUP;
               end else if (live_ff == FULL_CNT) begin
                  status_in = STAT_FULL;
               end else begin
                  add_wr   = 1'b1;
                  init_wr  = 1'b1;
                  init_idx = live_idx;
                  addr_in  = ADDR_W'(live_idx);
                  live_in  = live_ff + CNT_W'(1);
               end
            end
            ACT_LOOKUP, ACT_MARK: begin
               if (found_ff) begin
                  addr_in = ADDR_W'(fidx_ff);
                  init_wr = (op_ff == ACT_MARK);
               end else begin
                  status_in = STAT_MISSING;
               end
            end
            ACT_ENTER: begin
               if (depth_ff >= DEPTH_TOP) status_in = STAT_LIMIT;
               else                       depth_in  = depth_ff + DEPTH_W'(1);
            end
            ACT_LEAVE: begin
               if (zero_ff)       status_in = STAT_AT_ZERO;
               else if (found_ff) live_in   = CNT_W'(fidx_ff);
            end
            default: ;
         endcase
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (add_wr) begin
         key_mem[live_idx]   <= key_ff;
         scope_mem[live_idx] <= depth_ff;
      end
      rkey_ff   <= key_mem[rd_idx];
      rscope_ff <= scope_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (init_wr) init_mem[init_idx] <= (op_ff == ACT_ADD) ? flag_ff : 1'b1;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_action;
         key_ff  <= req_name_key;
         flag_ff <= req_init_flag;
         zero_ff <= (depth_ff == '0);
      end
      if (issue) cidx_ff <= rd_idx;
      if (cmd.scan && stat.hit) fidx_ff <= cidx_ff;
      scan_ff   <= scan_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
         live_ff   <= '0;
         depth_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         live_ff   <= live_in;
         depth_ff  <= depth_in;
         strobe_ff <= cmd.commit;
         if (cmd.load)                  found_ff <= 1'b0;
         else if (cmd.scan && stat.hit) found_ff <= 1'b1;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_address     = addr_ff;
   assign rsp_depth_now   = depth_ff;
   assign rsp_entry_count = COUNT_W'(live_ff);

endmodule

/* sv/scoped_symbol_table.sv */
`timescale 1ns / 1ps
// scoped symbol table top level
//
// Compiler symbol table with nested scopes. A request word is taken when start
// is high and busy is low; it carries an action (add, lookup, mark initialized,
// enter scope, leave scope), a 64-bit packed name key and an init flag. Exactly
// one response word follows, shown on the rsp_ ports for a single cycle with
// rsp_strobe high; the receiver cannot stall it, so it must take the word in
// that cycle. Add, lookup, mark and leave walk the live entries from slot zero
// through the single read port of the table memory, one entry per cycle, and
// stop at the first match or after the last live entry, then commit and
// respond. Enter scope, leave at depth zero and unused action codes skip the
// walk and go straight to commit. busy drops in the cycle the response strobe
// is shown, so a new request may be issued right then. No clearing pass runs
// after reset: only slots below the live count are read.
module scoped_symbol_table #(
   parameter int ENTRIES   = 1024,
   parameter int MAX_DEPTH = 255
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [sst_pkg::ACTION_W-1:0]  req_action,
   input  logic [sst_pkg::KEY_W-1:0]     req_name_key,
   input  logic                          req_init_flag,
   output logic                          rsp_strobe,
   output logic [sst_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sst_pkg::ADDR_W-1:0]    rsp_address,
   output logic [sst_pkg::DEPTH_W-1:0]   rsp_depth_now,
   output logic [sst_pkg::COUNT_W-1:0]   rsp_entry_count
);
   import sst_pkg::*;

   cmd_type  cmd;    // load / scan / commit from the controller
   stat_type stat;   // scan results back from the datapath

   // sequencer: idle, walk the table, commit and respond
   sst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // table memories, depth and count, response word
   sst_dp #(
      .ENTRIES   (ENTRIES),
      .MAX_DEPTH (MAX_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_action),
      .req_name_key    (req_name_key),
      .req_init_flag   (req_init_flag),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_address     (rsp_address),
      .rsp_depth_now   (rsp_depth_now),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
